// ===== src/grr_pkg.sv =====
package grr_pkg;

  // Grid geometry.
  localparam int MAX_DIM = 64;
  localparam int DIM_CAP = (MAX_DIM / 2) * 2;
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int SIZE_W  = DIM_W + 1;
  localparam int PER_W   = DIM_W + 2;
  localparam int ADDR_W  = 2 * DIM_W;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int HALF_W  = 6;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = $clog2(DATA_W);

  // Configuration port.
  localparam int APB_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;
  localparam logic [REG_IDX_W-1:0] REG_ROWS_HALF = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_COLS_HALF = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROTATE    = 2'd2;

  // Commands.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic                     command;
    logic [5:0]               row;
    logic [5:0]               col;
    logic signed [DATA_W-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] rotated_value;
    logic                     bad_position;
  } out_item_t;

  // Rows or columns in use, saturated at the largest even size.
  function automatic logic [SIZE_W-1:0] dim_in_use(input logic [HALF_W-1:0] half);
    logic [HALF_W:0] n;
    n = {half, 1'b0};
    if (int'(n) > DIM_CAP) begin
      return SIZE_W'(DIM_CAP);
    end
    return SIZE_W'(n);
  endfunction

endpackage

// ===== src/grr_mod.sv =====
// Restoring remainder: one dividend bit per cycle.
module grr_mod (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [grr_pkg::DATA_W-1:0]       dividend_i,
  input  logic [grr_pkg::PER_W-1:0]        divisor_i,
  output logic                             done_o,
  output logic [grr_pkg::PER_W-1:0]        rem_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [grr_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic [grr_pkg::DATA_W-1:0]       quo_q, quo_d;
  logic [grr_pkg::PER_W-1:0]        rem_q, rem_d;
  logic [grr_pkg::PER_W-1:0]        div_q, div_d;
  logic [grr_pkg::PER_W:0]          trial;

  // One shift and conditional subtract per cycle.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    trial  = {rem_q, quo_q[grr_pkg::DATA_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[grr_pkg::DATA_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = grr_pkg::PER_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = grr_pkg::PER_W'(trial);
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == grr_pkg::CNT_W'(grr_pkg::DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== src/grid_ring_rotation.sv =====
// Channel  | Signals                              | Direction
// in       | in_valid_i, in_stall_o, in_item_i    | item into the block
// out      | out_valid_o, out_stall_i, out_item_o | result item out
// config   | psel, penable, pwrite, paddr, ...    | register writes and reads
//
// A load item does not stall the input, so loads can follow back to back.
// A read item passes the bit-serial remainder unit, one step per dividend
// bit and then a done flag, then the position map and grid read, and then
// the output register load; a read outside the configured size goes
// straight to the output register.
// Reset clears control state and registers, not the grid store; the input
// stalls while a read is in flight, and a stalled output holds the block.
module grid_ring_rotation (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  grr_pkg::in_item_t                 in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output grr_pkg::out_item_t                out_item_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [grr_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOD  = 2'd1;
  localparam logic [1:0] S_MAP  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  localparam int SW = grr_pkg::SIZE_W;
  localparam int PW = grr_pkg::PER_W;

  logic [1:0]                   state_q, state_d;
  logic [grr_pkg::HALF_W-1:0]   rows_half_q, cols_half_q;
  logic [grr_pkg::DATA_W-1:0]   rotate_q;
  logic [grr_pkg::REG_IDX_W-1:0] reg_idx;
  logic                         cfg_wr;

  logic                         in_acc;
  logic [SW-1:0]                nr, nc, r7, c7, dr, dc, dmin, hh, ww, lr, lc;
  logic                         in_range;
  logic [PW-1:0]                per, toff;

  logic [SW-1:0]                d_q, h_q, w_q;
  logic [PW-1:0]                per_q, t_q;
  logic                         bad_q;

  logic                         mod_start, mod_done;
  logic [PW-1:0]                rem;
  logic [PW:0]                  src_sum, src;
  logic [PW:0]                  h9, w9, d9, sr9, sc9;
  logic [grr_pkg::ADDR_W-1:0]   rd_addr, wr_addr;

  logic signed [grr_pkg::DATA_W-1:0] grid_mem [grr_pkg::DEPTH];
  logic signed [grr_pkg::DATA_W-1:0] rdata_q;

  logic                         out_valid_q;
  grr_pkg::out_item_t           out_q;
  logic                         out_free;

  // Configuration registers.
  assign reg_idx = paddr[grr_pkg::APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_half_q <= grr_pkg::HALF_W'(1);
      cols_half_q <= grr_pkg::HALF_W'(1);
      rotate_q    <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        grr_pkg::REG_ROWS_HALF: rows_half_q <= pwdata[grr_pkg::HALF_W-1:0];
        grr_pkg::REG_COLS_HALF: cols_half_q <= pwdata[grr_pkg::HALF_W-1:0];
        grr_pkg::REG_ROTATE:    rotate_q    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      grr_pkg::REG_ROWS_HALF: prdata = 32'(rows_half_q);
      grr_pkg::REG_COLS_HALF: prdata = 32'(cols_half_q);
      grr_pkg::REG_ROTATE:    prdata = rotate_q;
      default:                prdata = '0;
    endcase
  end

  // Ring geometry of the incoming position.
  assign in_acc   = in_valid_i && !in_stall_o;
  assign nr       = grr_pkg::dim_in_use(rows_half_q);
  assign nc       = grr_pkg::dim_in_use(cols_half_q);
  assign r7       = SW'(in_item_i.row);
  assign c7       = SW'(in_item_i.col);
  assign in_range = (r7 < nr) && (c7 < nc);

  always_comb begin
    logic [SW-1:0] m0, m1;
    dr   = nr - SW'(1) - r7;
    dc   = nc - SW'(1) - c7;
    m0   = (r7 < c7) ? r7 : c7;
    m1   = (dr < dc) ? dr : dc;
    dmin = (m0 < m1) ? m0 : m1;
    hh   = nr - {dmin[SW-2:0], 1'b0};
    ww   = nc - {dmin[SW-2:0], 1'b0};
    lr   = r7 - dmin;
    lc   = c7 - dmin;
    per  = PW'({hh, 1'b0}) + PW'({ww, 1'b0}) - PW'(4);
    if (lc == '0) begin
      toff = PW'(lr);
    end else if (lr == hh - SW'(1)) begin
      toff = PW'(hh) - PW'(1) + PW'(lc);
    end else if (lc == ww - SW'(1)) begin
      toff = PW'(hh) - PW'(1) + PW'(ww) - PW'(1) + PW'(hh) - PW'(1) - PW'(lr);
    end else begin
      toff = PW'({hh, 1'b0}) + PW'(ww) - PW'(3) + PW'(ww) - PW'(1) - PW'(lc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_item_i.command == grr_pkg::CMD_READ) begin
      d_q   <= dmin;
      h_q   <= hh;
      w_q   <= ww;
      per_q <= per;
      t_q   <= toff;
      bad_q <= !in_range;
    end
  end

  assign mod_start = in_acc && in_item_i.command == grr_pkg::CMD_READ && in_range;

  grr_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (rotate_q),
    .divisor_i  (per),
    .done_o     (mod_done),
    .rem_o      (rem)
  );

  // Source offset and its position on the ring.
  always_comb begin
    src_sum = {1'b0, t_q} + {1'b0, per_q} - {1'b0, rem};
    src     = (src_sum >= {1'b0, per_q}) ? src_sum - {1'b0, per_q} : src_sum;
    h9      = (PW+1)'(h_q);
    w9      = (PW+1)'(w_q);
    d9      = (PW+1)'(d_q);
    if (src < h9) begin
      sr9 = d9 + src;
      sc9 = d9;
    end else if (src < h9 + w9 - 1'b1) begin
      sr9 = d9 + h9 - 1'b1;
      sc9 = d9 + src - (h9 - 1'b1);
    end else if (src < {h9[PW-1:0], 1'b0} + w9 - 2'd2) begin
      sr9 = d9 + h9 - 1'b1 - (src - (h9 + w9 - 2'd2));
      sc9 = d9 + w9 - 1'b1;
    end else begin
      sr9 = d9;
      sc9 = d9 + w9 - 1'b1 - (src - ({h9[PW-1:0], 1'b0} + w9 - 2'd3));
    end
    rd_addr = {sr9[grr_pkg::DIM_W-1:0], sc9[grr_pkg::DIM_W-1:0]};
  end

  assign wr_addr = {in_item_i.row, in_item_i.col};

  // Grid store: one write port for loads, one registered read port.
  always_ff @(posedge clk_i) begin
    if (in_acc && in_item_i.command == grr_pkg::CMD_LOAD && in_range) begin
      grid_mem[wr_addr] <= in_item_i.element_value;
    end
    if (state_q == S_MAP) begin
      rdata_q <= grid_mem[rd_addr];
    end
  end

  // Sequencer.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && in_item_i.command == grr_pkg::CMD_READ) begin
          state_d = in_range ? S_MOD : S_OUT;
        end
      end
      S_MOD:   if (mod_done) state_d = S_MAP;
      S_MAP:   state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      out_q.rotated_value <= bad_q ? '0 : rdata_q;
      out_q.bad_position  <= bad_q;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_done_in_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> state_q == S_MOD)
    else $error("remainder finished outside its state");
  a_map_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MAP |=> state_q == S_OUT)
    else $error("grid read not followed by output stage");
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.bad_position |-> out_item_o.rotated_value == '0)
    else $error("flagged item carries a value");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT && !out_free |=> state_q == S_OUT)
    else $error("result dropped while output stalled");
`endif

endmodule

// ===== sim/grid_ring_rotation_test.sv =====
module grid_ring_rotation_test;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  grr_pkg::in_item_t in_item_i;
  logic out_valid_o;
  logic out_stall_i;
  grr_pkg::out_item_t out_item_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [grr_pkg::APB_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  grid_ring_rotation dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i(in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o(out_item_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  localparam int STALL_LIMIT = 5000;

  // Shadow of the grid and the registers, used to predict reads.
  logic [31:0] shadow_grid [grr_pkg::DEPTH];
  bit shadow_written [grr_pkg::DEPTH];
  int unsigned cfg_rows_half;
  int unsigned cfg_cols_half;
  logic [31:0] cfg_rotate;

  grr_pkg::in_item_t pending_items[$];
  grr_pkg::out_item_t expected_reads[$];
  int error_count;
  int idle_pct;
  int quiet_cycles;
  bit in_fired;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned used_dim(int unsigned half);
    int unsigned n;
    n = 2 * half;
    return (n > grr_pkg::DIM_CAP) ? grr_pkg::DIM_CAP : n;
  endfunction

  // Rotated lookup: find the ring, step back along it, fetch the source.
  function automatic grr_pkg::out_item_t predict_read(int unsigned r, int unsigned c);
    grr_pkg::out_item_t res;
    int unsigned nr, nc, d, h, w, per, t, src, sr, sc, lr, lc;
    nr = used_dim(cfg_rows_half);
    nc = used_dim(cfg_cols_half);
    res = '0;
    if (!(r < nr && c < nc)) begin
      res.bad_position = 1'b1;
      return res;
    end
    d = r;
    if (c < d) d = c;
    if (nr - 1 - r < d) d = nr - 1 - r;
    if (nc - 1 - c < d) d = nc - 1 - c;
    h = nr - 2 * d;
    w = nc - 2 * d;
    per = 2 * h + 2 * w - 4;
    lr = r - d;
    lc = c - d;
    if (lc == 0) t = lr;
    else if (lr == h - 1) t = h - 1 + lc;
    else if (lc == w - 1) t = (h - 1) + (w - 1) + (h - 1 - lr);
    else t = 2 * h + w - 3 + (w - 1 - lc);
    src = (t + per - (cfg_rotate % per)) % per;
    if (src < h) begin
      sr = d + src;
      sc = d;
    end else if (src < h + w - 1) begin
      sr = d + h - 1;
      sc = d + (src - (h - 1));
    end else if (src < 2 * h + w - 2) begin
      sr = d + h - 1 - (src - (h + w - 2));
      sc = d + w - 1;
    end else begin
      sr = d;
      sc = d + w - 1 - (src - (2 * h + w - 3));
    end
    res.rotated_value = shadow_grid[sr * grr_pkg::MAX_DIM + sc];
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Append an item to the pending queue.
  task automatic add_item(input grr_pkg::in_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  // Driver: inputs change at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_fired) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_item_i <= pending_items.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < idle_pct);
    end
  end

  // Monitor: predict at input acceptance, check at output acceptance.
  always @(posedge clk_i) begin
    bit took;
    took = 1'b0;
    if (rst_ni) begin
      in_fired <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        took = 1'b1;
        if (in_item_i.command == grr_pkg::CMD_LOAD) begin
          if (in_item_i.row < used_dim(cfg_rows_half)
              && in_item_i.col < used_dim(cfg_cols_half)) begin
            shadow_grid[in_item_i.row * grr_pkg::MAX_DIM + in_item_i.col] =
              in_item_i.element_value;
          end
        end else begin
          expected_reads.insert(expected_reads.size(),
                                predict_read(in_item_i.row, in_item_i.col));
        end
      end
      if (out_valid_o && !out_stall_i) begin
        took = 1'b1;
        if (expected_reads.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          grr_pkg::out_item_t exp_item;
          exp_item = expected_reads.pop_front();
          if (out_item_o.rotated_value !== exp_item.rotated_value)
            report_mismatch($sformatf("rotated_value got %0d want %0d",
              out_item_o.rotated_value, exp_item.rotated_value));
          if (out_item_o.bad_position !== exp_item.bad_position)
            report_mismatch($sformatf("bad_position got %0b want %0b",
              out_item_o.bad_position, exp_item.bad_position));
        end
      end
      if (took) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [grr_pkg::REG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= grr_pkg::APB_ADDR_W'(4 * idx);
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (idx == grr_pkg::REG_ROWS_HALF) cfg_rows_half = value[5:0];
    else if (idx == grr_pkg::REG_COLS_HALF) cfg_cols_half = value[5:0];
    else cfg_rotate = value;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Wait for the queues to drain, then cover the read latency.
  task automatic drain();
    while (pending_items.size() > 0 || expected_reads.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic grr_pkg::in_item_t make_item(logic cmd, int unsigned r,
                                                  int unsigned c, logic [31:0] v);
    grr_pkg::in_item_t it;
    it.command = cmd;
    it.row = r[5:0];
    it.col = c[5:0];
    it.element_value = v;
    return it;
  endfunction

  // Fill the whole used area, tracking what has been written.
  task automatic queue_fill(input int unsigned nr, input int unsigned nc, input bit ramp);
    for (int unsigned i = 0; i < nr; i++) begin
      for (int unsigned j = 0; j < nc; j++) begin
        logic [31:0] v;
        v = ramp ? 32'(i * 100 + j) : $urandom();
        add_item(make_item(grr_pkg::CMD_LOAD, i, j, v));
        shadow_written[i * grr_pkg::MAX_DIM + j] = 1'b1;
      end
    end
  endtask

  // One phase: configure, fill, then a mix of loads and reads, mostly at legal positions.
  task automatic run_phase(input int unsigned rh, input int unsigned ch,
                           input logic [31:0] rot, input int n_items);
    int unsigned nr, nc, r, c;
    write_reg(grr_pkg::REG_ROWS_HALF, rh);
    write_reg(grr_pkg::REG_COLS_HALF, ch);
    write_reg(grr_pkg::REG_ROTATE, rot);
    nr = used_dim(rh);
    nc = used_dim(ch);
    queue_fill(nr, nc, 1'b0);
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(9) < 8 && nr > 0 && nc > 0) begin
        r = $urandom_range(nr - 1);
        c = $urandom_range(nc - 1);
      end else begin
        r = $urandom_range(63);
        c = $urandom_range(63);
      end
      if ($urandom_range(3) == 0) begin
        add_item(make_item(grr_pkg::CMD_LOAD, r, c, $urandom()));
        if (r < nr && c < nc) shadow_written[r * grr_pkg::MAX_DIM + c] = 1'b1;
      end else if (r >= nr || c >= nc || shadow_written[r * grr_pkg::MAX_DIM + c]) begin
        add_item(make_item(grr_pkg::CMD_READ, r, c, $urandom()));
      end
    end
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_stall_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    error_count = 0;
    quiet_cycles = 0;
    in_fired = 1'b0;
    idle_pct = 33;
    cfg_rows_half = 1;
    cfg_cols_half = 1;
    cfg_rotate = '0;
    for (int i = 0; i < grr_pkg::DEPTH; i++) begin
      shadow_grid[i] = '0;
      shadow_written[i] = 1'b0;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset 2x2 grid, extreme values, reads inside and outside.
    add_item(make_item(grr_pkg::CMD_LOAD, 0, 0, 32'h8000_0000));
    add_item(make_item(grr_pkg::CMD_LOAD, 1, 0, 32'h7fff_ffff));
    add_item(make_item(grr_pkg::CMD_LOAD, 1, 1, 32'hffff_ffff));
    add_item(make_item(grr_pkg::CMD_LOAD, 0, 1, 32'h0));
    add_item(make_item(grr_pkg::CMD_LOAD, 63, 63, 32'h1234_5678));
    for (int i = 0; i < 4; i++)
      shadow_written[(i / 2) * grr_pkg::MAX_DIM + (i % 2)] = 1'b1;
    add_item(make_item(grr_pkg::CMD_READ, 0, 0, 32'hffff_ffff));
    add_item(make_item(grr_pkg::CMD_READ, 1, 1, 32'h0));
    add_item(make_item(grr_pkg::CMD_READ, 63, 0, 32'h0));
    add_item(make_item(grr_pkg::CMD_READ, 0, 63, 32'h0));
    add_item(make_item(grr_pkg::CMD_READ, 2, 2, 32'h0));
    drain();

    // Zero half size: everything is outside.
    write_reg(grr_pkg::REG_ROWS_HALF, 32'd0);
    write_reg(grr_pkg::REG_COLS_HALF, 32'd3);
    add_item(make_item(grr_pkg::CMD_LOAD, 0, 0, 32'h5555_aaaa));
    add_item(make_item(grr_pkg::CMD_READ, 0, 0, 32'h0));
    add_item(make_item(grr_pkg::CMD_READ, 63, 63, 32'h0));
    drain();

    // Random phases over several geometries and rotations, extremes included.
    idle_pct = 33;
    run_phase(2, 3, 32'd1, 80);
    run_phase(3, 2, 32'hffff_ffff, 80);
    run_phase(1, 32, 32'd7, 80);
    idle_pct = 0;
    run_phase(4, 4, 32'd13, 80);
    idle_pct = 33;
    run_phase(32, 1, 32'h8000_0001, 80);
    run_phase(5, 3, $urandom(), 80);
    run_phase(63, 2, $urandom(), 80);
    run_phase(2, 2, 32'd0, 80);

    if (error_count == 0 && expected_reads.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
